// ----- rtl/core/pet_pkg.sv -----
// ----------------------------------------------------------------------------
// pet_pkg
// Shared types, sizes and saturation helpers for the extrapolation tableau.
// ----------------------------------------------------------------------------
package pet_pkg;

  // sizing
  localparam int NUM_VARS  = 64;
  localparam int MAX_STEPS = 64;
  localparam int VAR_W     = (NUM_VARS > 1) ? $clog2(NUM_VARS) : 1;
  localparam int STEP_W    = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
  localparam int DIV_W     = 64;
  localparam int DCNT_W    = $clog2(DIV_W + 1);

  // input beat
  typedef struct packed {
    logic [5:0]         estimate_index;
    logic [31:0]        step_measure;
    logic [5:0]         var_index;
    logic signed [31:0] estimate;
  } in_t;

  // result beat
  typedef struct packed {
    logic [5:0]         var_index_out;
    logic signed [31:0] extrapolated;
    logic signed [31:0] error_estimate;
    logic               saturated;
    logic               bad_step;
  } out_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic start;
    logic rd;
    logic diff;
    logic mag;
    logic mula;
    logic mulb;
    logic addb;
    logic div_start;
    logic fin;
    logic final_wr;
    logic out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic var_ok;
    logic pos_zero;
    logic last_col;
    logic div_done;
  } stat_t;

  // clipped value with its clip flag
  typedef struct packed {
    logic               clip;
    logic signed [31:0] val;
  } sat_t;

  // clip a 33-bit sum to 32 bits
  function automatic sat_t sat33(input logic signed [32:0] v);
    sat_t r;
    if (v[32] != v[31]) begin
      r.clip = 1'b1;
      r.val  = v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      r.clip = 1'b0;
      r.val  = v[31:0];
    end
    return r;
  endfunction

  // apply sign to an unsigned quotient, clipping to 32 bits
  function automatic sat_t fix_quo(input logic [63:0] q, input logic neg);
    sat_t r;
    r.clip = 1'b0;
    if (neg) begin
      if (q > 64'h8000_0000) begin
        r.clip = 1'b1;
        r.val  = 32'sh8000_0000;
      end else begin
        r.val  = ~q[31:0] + 32'd1;
      end
    end else begin
      if (q > 64'h7FFF_FFFF) begin
        r.clip = 1'b1;
        r.val  = 32'sh7FFF_FFFF;
      end else begin
        r.val  = q[31:0];
      end
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/pet_div.sv -----
// ----------------------------------------------------------------------------
// pet_div
// Restoring divider, one quotient bit per cycle, 64-bit dividend.
// ----------------------------------------------------------------------------
module pet_div (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [pet_pkg::DIV_W-1:0] num,
  input  logic [31:0]             den,
  output logic                    done,
  output logic [pet_pkg::DIV_W-1:0] quo
);
  import pet_pkg::*;

  logic              run_r;
  logic              done_r;
  logic [DCNT_W-1:0] cnt_r;
  logic [31:0]       rem_r;
  logic [31:0]       den_r;
  logic [DIV_W-1:0]  quo_r;
  logic [32:0]       trial;
  logic              fits;

  // trial subtract of the shifted remainder
  assign trial = {rem_r, quo_r[DIV_W-1]};
  assign fits  = trial >= {1'b0, den_r};

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + DCNT_W'(1);
        if (cnt_r == DCNT_W'(DIV_W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      den_r <= den;
      quo_r <= num;
    end else if (run_r) begin
      rem_r <= fits ? 32'(trial - {1'b0, den_r}) : trial[31:0];
      quo_r <= {quo_r[DIV_W-2:0], fits};
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

`ifndef NO_ASSERTIONS
  a_done_after_run: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(run_r)) else $error("divider done without a run");
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !run_r) else $error("divider restarted while busy");
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    run_r && !start && den_r != 32'd0 |-> rem_r < den_r)
    else $error("divider remainder out of range");
`endif

endmodule

// ----- rtl/core/pet_ctrl.sv -----
// ----------------------------------------------------------------------------
// pet_ctrl
// Sequencer: walks the tableau columns of one beat and drives the datapath.
// ----------------------------------------------------------------------------
module pet_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  pet_pkg::stat_t st,
  output pet_pkg::cmd_t  cmd
);
  import pet_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_START, S_RD, S_DIFF, S_MAG, S_MULA, S_MULB, S_ADDB,
    S_DIVS, S_DIVW, S_FIN, S_FINAL, S_OUTL, S_OUT
  } state_t;

  state_t state_r;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      case (state_r)
        S_IDLE:  if (in_valid) state_r <= S_START;
        S_START: state_r <= (!st.var_ok || st.pos_zero) ? S_OUTL : S_RD;
        S_RD:    state_r <= S_DIFF;
        S_DIFF:  state_r <= S_MAG;
        S_MAG:   state_r <= S_MULA;
        S_MULA:  state_r <= S_MULB;
        S_MULB:  state_r <= S_ADDB;
        S_ADDB:  state_r <= S_DIVS;
        S_DIVS:  state_r <= S_DIVW;
        S_DIVW:  if (st.div_done) state_r <= S_FIN;
        S_FIN:   state_r <= st.last_col ? S_FINAL : S_RD;
        S_FINAL: state_r <= S_OUTL;
        S_OUTL:  state_r <= S_OUT;
        S_OUT:   if (out_ready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // command decode
  always_comb begin
    cmd           = '0;
    cmd.load      = (state_r == S_IDLE) && in_valid;
    cmd.start     = state_r == S_START;
    cmd.rd        = state_r == S_RD;
    cmd.diff      = state_r == S_DIFF;
    cmd.mag       = state_r == S_MAG;
    cmd.mula      = state_r == S_MULA;
    cmd.mulb      = state_r == S_MULB;
    cmd.addb      = state_r == S_ADDB;
    cmd.div_start = state_r == S_DIVS;
    cmd.fin       = state_r == S_FIN;
    cmd.final_wr  = state_r == S_FINAL;
    cmd.out_load  = state_r == S_OUTL;
  end

  assign in_ready  = state_r == S_IDLE;
  assign out_valid = state_r == S_OUT;

`ifndef NO_ASSERTIONS
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("input and result sides both open");
  a_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    st.div_done |-> state_r == S_DIVW) else $error("divider done out of step");
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FIN && st.last_col |=> state_r == S_FINAL)
    else $error("last column not closed");
`endif

endmodule

// ----- rtl/core/pet_dp.sv -----
// ----------------------------------------------------------------------------
// pet_dp
// Datapath: step history, tableau memory, shared multiplier and two dividers.
// ----------------------------------------------------------------------------
module pet_dp (
  input  logic           clk,
  input  logic           rst_n,
  input  pet_pkg::in_t   in_data,
  input  pet_pkg::cmd_t  cmd,
  output pet_pkg::stat_t st,
  output pet_pkg::out_t  out_data
);
  import pet_pkg::*;

  localparam int TAB_AW = VAR_W + STEP_W;

  logic [31:0]        hist_mem [2**STEP_W];
  logic signed [31:0] tab_mem  [2**TAB_AW];

  in_t                in_r;
  out_t               out_r;
  logic [STEP_W-1:0]  pos_r, k_r;
  logic signed [31:0] yz_r, yerr_r, carry_r, diff_r, tab_q_r;
  logic [31:0]        hist_q_r, prev_r, mag_r, den_r;
  logic               sat_r, bad_r, eq_r, neg_r;
  logic [63:0]        prod_r, num_a_r, num_b_r;

  logic [VAR_W-1:0]   var_ix;
  logic [STEP_W-1:0]  pos_in;
  logic               var_ok;
  logic [STEP_W-1:0]  hist_ra;
  logic [TAB_AW-1:0]  tab_ra, tab_wa;
  logic signed [31:0] tab_wd;
  logic               tab_we;
  logic [63:0]        half;
  logic [63:0]        quo_a, quo_b;
  logic               done_a, done_b;
  sat_t               dsat, fa, fb, ysum;
  logic signed [31:0] yerr_new, carry_new;

  // addressing
  assign var_ix  = VAR_W'(in_r.var_index);
  assign var_ok  = 32'(in_r.var_index) < 32'(NUM_VARS);
  assign pos_in  = (32'(in_data.estimate_index) >= 32'(MAX_STEPS)) ?
                   STEP_W'(MAX_STEPS - 1) : STEP_W'(in_data.estimate_index);
  assign hist_ra = pos_r - k_r - STEP_W'(1);
  assign tab_ra  = {var_ix, k_r};

  // single tableau write port
  always_comb begin
    tab_we = 1'b0;
    tab_wa = tab_ra;
    tab_wd = yerr_r;
    if (cmd.start) begin
      tab_we = var_ok && (pos_r == '0);
      tab_wa = {var_ix, STEP_W'(0)};
      tab_wd = in_r.estimate;
    end else if (cmd.diff) begin
      tab_we = 1'b1;
    end else if (cmd.final_wr) begin
      tab_we = 1'b1;
      tab_wa = {var_ix, pos_r};
    end
  end

  // memories
  always_ff @(posedge clk) begin
    if (cmd.start && var_ok) hist_mem[pos_r] <= in_r.step_measure;
    if (cmd.rd) hist_q_r <= hist_mem[hist_ra];
  end

  always_ff @(posedge clk) begin
    if (tab_we) tab_mem[tab_wa] <= tab_wd;
    if (cmd.rd) tab_q_r <= tab_mem[tab_ra];
  end

  // column arithmetic
  assign dsat = sat33({carry_r[31], carry_r} - {tab_q_r[31], tab_q_r});
  assign half = 64'(den_r >> 1);
  assign fa   = fix_quo(quo_a, neg_r);
  assign fb   = fix_quo(quo_b, neg_r);
  assign yerr_new  = eq_r ? 32'sd0 : fa.val;
  assign carry_new = eq_r ? 32'sd0 : fb.val;
  assign ysum = sat33({yz_r[31], yz_r} + {yerr_new[31], yerr_new});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sat_r <= 1'b0;
      bad_r <= 1'b0;
      k_r   <= '0;
    end else if (cmd.load) begin
      sat_r <= 1'b0;
      bad_r <= 1'b0;
      k_r   <= '0;
    end else begin
      if (cmd.diff && dsat.clip) sat_r <= 1'b1;
      if (cmd.fin) begin
        if (eq_r) bad_r <= 1'b1;
        if ((!eq_r && (fa.clip || fb.clip)) || ysum.clip) sat_r <= 1'b1;
        k_r <= k_r + STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_r    <= in_data;
      pos_r   <= pos_in;
      yz_r    <= in_data.estimate;
      yerr_r  <= in_data.estimate;
      carry_r <= in_data.estimate;
    end
    if (cmd.diff) begin
      diff_r <= dsat.val;
      prev_r <= hist_q_r;
      eq_r   <= hist_q_r == in_r.step_measure;
    end
    if (cmd.mag) begin
      mag_r <= diff_r[31] ? (~diff_r + 32'd1) : diff_r;
      den_r <= (prev_r > in_r.step_measure) ? prev_r - in_r.step_measure
                                            : in_r.step_measure - prev_r;
      neg_r <= diff_r[31] != (prev_r < in_r.step_measure);
    end
    // one multiplier, result registered before the rounding add
    if (cmd.mula) prod_r <= 64'(mag_r) * 64'(in_r.step_measure);
    if (cmd.mulb) begin
      num_a_r <= prod_r + half;
      prod_r  <= 64'(mag_r) * 64'(prev_r);
    end
    if (cmd.addb) num_b_r <= prod_r + half;
    if (cmd.fin) begin
      yerr_r  <= yerr_new;
      carry_r <= carry_new;
      yz_r    <= ysum.val;
    end
    if (cmd.out_load) begin
      out_r.var_index_out  <= in_r.var_index;
      out_r.extrapolated   <= yz_r;
      out_r.error_estimate <= yerr_r;
      out_r.saturated      <= sat_r;
      out_r.bad_step       <= bad_r;
    end
  end

  // correction and carry quotients run side by side
  pet_div u_div_a (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start),
    .num(num_a_r), .den(den_r), .done(done_a), .quo(quo_a)
  );

  pet_div u_div_b (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start),
    .num(num_b_r), .den(den_r), .done(done_b), .quo(quo_b)
  );

  assign st.var_ok   = var_ok;
  assign st.pos_zero = pos_r == '0;
  assign st.last_col = k_r == pos_r - STEP_W'(1);
  assign st.div_done = done_a;
  assign out_data    = out_r;

`ifndef NO_ASSERTIONS
  a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    done_a == done_b) else $error("dividers out of step");
  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd |-> k_r < pos_r) else $error("column beyond position");
  a_wr_ok: assert property (@(posedge clk) disable iff (!rst_n)
    tab_we |-> var_ok) else $error("tableau write for absent variable");
`endif

endmodule

// ----- rtl/core/polynomial_extrapolation_tableau_core.sv -----
// ----------------------------------------------------------------------------
// polynomial_extrapolation_tableau_core
// Neville-form polynomial extrapolation to zero step, one beat at a time.
// ----------------------------------------------------------------------------
// One beat in, one beat out. A beat at position 0 stores the estimate and
// occupies the block from the accepting cycle to the cycle in which its
// result is taken. A beat at position i walks i tableau columns; each
// column reads, differences, multiplies and then waits on the two
// bit-serial dividers that form the correction and the carry in parallel,
// and the result is held while the result side stalls. The block accepts
// no new beat until the result has been taken. Step history and tableau
// are plain memories with no reset; feed position 0 of a sequence before
// later positions of the same variable.
module polynomial_extrapolation_tableau_core (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  pet_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output pet_pkg::out_t out_data
);
  import pet_pkg::*;

  cmd_t  cmd;
  stat_t st;

  // sequencer
  pet_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready),
    .st(st), .cmd(cmd)
  );

  // datapath
  pet_dp u_dp (
    .clk(clk), .rst_n(rst_n),
    .in_data(in_data), .cmd(cmd), .st(st), .out_data(out_data)
  );

endmodule
